[hw/rtl/trf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle raster fill package
// Shared types and constants of the triangle fill block.
// ----------------------------------------------------------------------------
package trf_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int AddrW     = XW + YW;
  localparam int Depth     = MaxWidth * MaxHeight;

  localparam int CoordW = 12;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int EdgeW  = ProdW + 2;
  localparam int SizeW  = 7;
  localparam int CountW = 13;
  localparam int ColorW = 32;
  localparam int PosW   = 6;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } trf_op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } trf_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BOX,
    ST_SETUP,
    ST_RASTER,
    ST_CLEAR,
    ST_READ,
    ST_READ_DATA
  } trf_state_e;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic [ColorW-1:0]        fill_color;
    logic [PosW-1:0]          read_x;
    logic [PosW-1:0]          read_y;
  } trf_item_t;

  typedef struct packed {
    logic [ColorW-1:0] read_value;
    logic [CountW-1:0] pixels_written;
    logic              degenerate;
  } trf_result_t;

  // Signed area and the edge functions e0, e1 and e2 at the box origin.
  typedef struct packed {
    logic signed [EdgeW-1:0] area;
    logic signed [EdgeW-1:0] e0;
    logic signed [EdgeW-1:0] e1;
    logic signed [EdgeW-1:0] e2;
  } trf_edges_t;

endpackage
`default_nettype wire

[hw/rtl/trf_frame_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Frame store memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trf_frame_mem import trf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [ColorW-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic      [ColorW-1:0] rdata_o
);

  logic [ColorW-1:0] store_q [Depth];
  logic [ColorW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/trf_edge_setup.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Edge setup unit
// Computes the signed area and the edge functions e0, e1 and e2 at the box
// origin with one shared multiplier, one product per cycle.
// ----------------------------------------------------------------------------
module trf_edge_setup import trf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire trf_item_t       item_i,
  input  wire logic [XW-1:0]   org_x_i,
  input  wire logic [YW-1:0]   org_y_i,
  output logic                 done_o,
  output trf_edges_t           edges_o
);

  logic                    run_q, run_d;
  logic [2:0]              step_q, step_d;
  logic                    pvalid_q;
  logic [2:0]              pstep_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [EdgeW-1:0] acc_q [4];
  logic                    done_q;

  logic signed [DiffW-1:0] x0, y0, x1, y1, x2, y2, px, py;
  logic signed [DiffW-1:0] op_a, op_b;

  assign x0 = DiffW'(item_i.v0_x);
  assign y0 = DiffW'(item_i.v0_y);
  assign x1 = DiffW'(item_i.v1_x);
  assign y1 = DiffW'(item_i.v1_y);
  assign x2 = DiffW'(item_i.v2_x);
  assign y2 = DiffW'(item_i.v2_y);
  assign px = $signed({{(DiffW-XW){1'b0}}, org_x_i});
  assign py = $signed({{(DiffW-YW){1'b0}}, org_y_i});

  // Even steps give the first product of a pair, odd steps the subtracted one.
  always_comb begin
    case (step_q)
      3'd0:    begin op_a = x1 - x0; op_b = y2 - y0; end
      3'd1:    begin op_a = y1 - y0; op_b = x2 - x0; end
      3'd2:    begin op_a = x2 - x1; op_b = py - y1; end
      3'd3:    begin op_a = y2 - y1; op_b = px - x1; end
      3'd4:    begin op_a = x0 - x2; op_b = py - y2; end
      3'd5:    begin op_a = y0 - y2; op_b = px - x2; end
      3'd6:    begin op_a = x1 - x0; op_b = py - y0; end
      default: begin op_a = y1 - y0; op_b = px - x0; end
    endcase
  end

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    if (go_i) begin
      run_d  = 1'b1;
      step_d = '0;
    end else if (run_q) begin
      step_d = step_q + 3'd1;
      if (step_q == 3'd7) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      step_q   <= '0;
      pvalid_q <= 1'b0;
      pstep_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      run_q    <= run_d;
      step_q   <= step_d;
      pvalid_q <= run_q;
      pstep_q  <= step_q;
      done_q   <= pvalid_q && (pstep_q == 3'd7);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (pvalid_q) begin
      if (!pstep_q[0]) begin
        acc_q[pstep_q[2:1]] <= EdgeW'(prod_q);
      end else begin
        acc_q[pstep_q[2:1]] <= acc_q[pstep_q[2:1]] - EdgeW'(prod_q);
      end
    end
  end

  assign done_o        = done_q;
  assign edges_o.area  = acc_q[0];
  assign edges_o.e0    = acc_q[1];
  assign edges_o.e1    = acc_q[2];
  assign edges_o.e2    = acc_q[3];

endmodule
`default_nettype wire

[hw/rtl/triangle_raster_fill.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle raster fill
// Half-space triangle fill into a 64 x 64 frame store of 32-bit pixels.
// ----------------------------------------------------------------------------
// After reset the block sweeps the frame store to zero with busy high. An
// item is taken when start is high and busy is low, and each item returns
// exactly one result, shown on result_o for one cycle while result_valid_o
// is high; the receiver cannot stall it. A draw keeps busy high through
// bounding box setup (ST_BOX), edge setup on the shared multiplier
// (ST_SETUP) and a walk over the clipped bounding box at one pixel per
// cycle, the rate of the frame store write port; a zero-area, reversed or
// fully clipped triangle ends after setup. A read keeps busy high through
// its ST_READ and ST_READ_DATA states, a clear through a sweep of the whole
// store, one store word per cycle, and an unknown op not at all. The result
// shows in the first cycle after busy falls, or in the cycle after the
// transfer for an unknown op.
// ----------------------------------------------------------------------------
module triangle_raster_fill import trf_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire trf_item_t     item_i,
  output logic               result_valid_o,
  output trf_result_t        result_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  trf_state_e  state_q, state_d;
  trf_item_t   item_q, item_d;
  trf_result_t res_q, res_d;
  logic        valid_q, valid_d;

  logic [SizeW-1:0] width_q, height_q;
  logic [SizeW-1:0] w_act, h_act;

  logic [AddrW-1:0] clr_q, clr_d;
  logic             clr_last;

  logic [XW-1:0] lo_x_q, lo_x_d, hi_x_q, hi_x_d, x_q, x_d;
  logic [YW-1:0] lo_y_q, lo_y_d, hi_y_q, hi_y_d, y_q, y_d;
  logic          empty_q, empty_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic signed [DiffW-1:0] sx_q [3];
  logic signed [DiffW-1:0] sy_q [3];
  logic signed [DiffW-1:0] sx_d [3];
  logic signed [DiffW-1:0] sy_d [3];
  logic signed [EdgeW-1:0] erow_q [3];
  logic signed [EdgeW-1:0] ecur_q [3];
  logic signed [EdgeW-1:0] erow_d [3];
  logic signed [EdgeW-1:0] ecur_d [3];

  logic       setup_go, setup_done;
  trf_edges_t edges;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [ColorW-1:0] mem_wdata, mem_rdata;

  logic covered, x_last, y_last, skip_draw, read_in;

  logic signed [DiffW-1:0] minx, maxx, miny, maxy, lox_s, hix_s, loy_s, hiy_s;
  logic signed [DiffW-1:0] wm1, hm1;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v,
                                                   logic [SizeW-1:0] m);
    logic [SizeW-1:0] r;
    r = v;
    if (r == '0) r = SizeW'(1);
    if (r > m) r = m;
    return r;
  endfunction

  function automatic logic signed [DiffW-1:0] min3(logic signed [DiffW-1:0] a,
                                                   logic signed [DiffW-1:0] b,
                                                   logic signed [DiffW-1:0] c);
    logic signed [DiffW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [DiffW-1:0] max3(logic signed [DiffW-1:0] a,
                                                   logic signed [DiffW-1:0] b,
                                                   logic signed [DiffW-1:0] c);
    logic signed [DiffW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(MaxWidth);
      height_q <= SizeW'(MaxHeight);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[SizeW-1:0];
      end else begin
        height_q <= pwdata[SizeW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-SizeW){1'b0}}, height_q}
                                           : {{(32-SizeW){1'b0}}, width_q};

  assign w_act = clamp_size(width_q, SizeW'(MaxWidth));
  assign h_act = clamp_size(height_q, SizeW'(MaxHeight));
  assign wm1   = $signed({{(DiffW-SizeW){1'b0}}, w_act - SizeW'(1)});
  assign hm1   = $signed({{(DiffW-SizeW){1'b0}}, h_act - SizeW'(1)});

  // Bounding box, clipped to the active image.
  assign minx  = min3(DiffW'(item_q.v0_x), DiffW'(item_q.v1_x), DiffW'(item_q.v2_x));
  assign maxx  = max3(DiffW'(item_q.v0_x), DiffW'(item_q.v1_x), DiffW'(item_q.v2_x));
  assign miny  = min3(DiffW'(item_q.v0_y), DiffW'(item_q.v1_y), DiffW'(item_q.v2_y));
  assign maxy  = max3(DiffW'(item_q.v0_y), DiffW'(item_q.v1_y), DiffW'(item_q.v2_y));
  assign lox_s = (minx < 0) ? '0 : minx;
  assign loy_s = (miny < 0) ? '0 : miny;
  assign hix_s = (maxx > wm1) ? wm1 : maxx;
  assign hiy_s = (maxy > hm1) ? hm1 : maxy;

  assign clr_last = (clr_q == AddrW'(Depth - 1));
  assign covered  = (ecur_q[0] >= 0) && (ecur_q[1] >= 0) && (ecur_q[2] >= 0);
  assign x_last   = (x_q == hi_x_q);
  assign y_last   = (y_q == hi_y_q);
  // The edge functions e0, e1 and e2 sum to the area, so a negative area covers nothing.
  assign skip_draw = (edges.area <= 0) || empty_q;
  assign read_in   = ({1'b0, item_q.read_x} < w_act) && ({1'b0, item_q.read_y} < h_act);

  assign setup_go = (state_q == ST_BOX);
  assign busy     = (state_q != ST_IDLE);

  trf_edge_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (setup_go),
    .item_i  (item_q),
    .org_x_i (lo_x_q),
    .org_y_i (lo_y_q),
    .done_o  (setup_done),
    .edges_o (edges)
  );

  trf_frame_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (item_i.op)
            OP_DRAW:  state_d = ST_BOX;
            OP_READ:  state_d = ST_READ;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_BOX:       state_d = ST_SETUP;
      ST_SETUP: begin
        if (setup_done) state_d = skip_draw ? ST_IDLE : ST_RASTER;
      end
      ST_RASTER: begin
        if (x_last && y_last) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_READ:      state_d = ST_READ_DATA;
      ST_READ_DATA: state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_d  = item_q;
    res_d   = res_q;
    valid_d = 1'b0;
    clr_d   = clr_q;
    lo_x_d  = lo_x_q;
    hi_x_d  = hi_x_q;
    lo_y_d  = lo_y_q;
    hi_y_d  = hi_y_q;
    empty_d = empty_q;
    x_d     = x_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    for (int i = 0; i < 3; i++) begin
      sx_d[i]   = sx_q[i];
      sy_d[i]   = sy_q[i];
      erow_d[i] = erow_q[i];
      ecur_d[i] = ecur_q[i];
    end
    mem_we    = 1'b0;
    mem_waddr = {y_q, x_q};
    mem_wdata = item_q.fill_color;
    mem_re    = 1'b0;
    mem_raddr = {item_q.read_y[YW-1:0], item_q.read_x[XW-1:0]};

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_last && (state_q == ST_CLEAR)) begin
          valid_d = 1'b1;
          res_d   = '0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          clr_d  = '0;
          if ((item_i.op != OP_DRAW) && (item_i.op != OP_READ) &&
              (item_i.op != OP_CLEAR)) begin
            valid_d = 1'b1;
            res_d   = '0;
          end
        end
      end
      ST_BOX: begin
        lo_x_d  = lox_s[XW-1:0];
        hi_x_d  = hix_s[XW-1:0];
        lo_y_d  = loy_s[YW-1:0];
        hi_y_d  = hiy_s[YW-1:0];
        empty_d = (lox_s > hix_s) || (loy_s > hiy_s);
        // Per-step increments: along x add (ay - by), along y add (bx - ax).
        sx_d[0] = DiffW'(item_q.v1_y) - DiffW'(item_q.v2_y);
        sy_d[0] = DiffW'(item_q.v2_x) - DiffW'(item_q.v1_x);
        sx_d[1] = DiffW'(item_q.v2_y) - DiffW'(item_q.v0_y);
        sy_d[1] = DiffW'(item_q.v0_x) - DiffW'(item_q.v2_x);
        sx_d[2] = DiffW'(item_q.v0_y) - DiffW'(item_q.v1_y);
        sy_d[2] = DiffW'(item_q.v1_x) - DiffW'(item_q.v0_x);
      end
      ST_SETUP: begin
        if (setup_done) begin
          x_d       = lo_x_q;
          y_d       = lo_y_q;
          cnt_d     = '0;
          erow_d[0] = edges.e0;
          erow_d[1] = edges.e1;
          erow_d[2] = edges.e2;
          ecur_d[0] = edges.e0;
          ecur_d[1] = edges.e1;
          ecur_d[2] = edges.e2;
          if (skip_draw) begin
            valid_d          = 1'b1;
            res_d            = '0;
            res_d.degenerate = (edges.area == 0);
          end
        end
      end
      ST_RASTER: begin
        mem_we = covered;
        cnt_d  = cnt_q + CountW'(covered);
        if (x_last) begin
          x_d = lo_x_q;
          y_d = y_q + YW'(1);
          for (int i = 0; i < 3; i++) begin
            erow_d[i] = erow_q[i] + EdgeW'(sy_q[i]);
            ecur_d[i] = erow_q[i] + EdgeW'(sy_q[i]);
          end
          if (y_last) begin
            valid_d              = 1'b1;
            res_d                = '0;
            res_d.pixels_written = cnt_q + CountW'(covered);
          end
        end else begin
          x_d = x_q + XW'(1);
          for (int i = 0; i < 3; i++) begin
            ecur_d[i] = ecur_q[i] + EdgeW'(sx_q[i]);
          end
        end
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_READ_DATA: begin
        valid_d          = 1'b1;
        res_d            = '0;
        res_d.read_value = read_in ? mem_rdata : '0;
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      valid_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    res_q   <= res_d;
    lo_x_q  <= lo_x_d;
    hi_x_q  <= hi_x_d;
    lo_y_q  <= lo_y_d;
    hi_y_q  <= hi_y_d;
    empty_q <= empty_d;
    x_q     <= x_d;
    y_q     <= y_d;
    cnt_q   <= cnt_d;
    for (int i = 0; i < 3; i++) begin
      sx_q[i]   <= sx_d[i];
      sy_q[i]   <= sy_d[i];
      erow_q[i] <= erow_d[i];
      ecur_q[i] <= ecur_d[i];
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule
`default_nettype wire
